@@ design/stk_pkg.sv @@
// Shared types, codes and helpers for the STK500 command engine.
`default_nettype none
package stk_pkg;
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int BUFFER_BYTES_DEF = 256;
    localparam int ADDR_W = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RES = 5;

    localparam logic [1:0] CMD_SERIAL = 2'd0;
    localparam logic [1:0] CMD_FLASH_DATA = 2'd1;
    localparam logic [1:0] CMD_FLASH_DONE = 2'd2;

    localparam logic [7:0] OP_GET_PARAM   = 8'h41;
    localparam logic [7:0] OP_SET_DEV     = 8'h42;
    localparam logic [7:0] OP_SET_DEV_EXT = 8'h45;
    localparam logic [7:0] OP_LEAVE       = 8'h51;
    localparam logic [7:0] OP_LOAD_ADDR   = 8'h55;
    localparam logic [7:0] OP_UNIVERSAL   = 8'h56;
    localparam logic [7:0] OP_PROG_PAGE   = 8'h64;
    localparam logic [7:0] OP_READ_PAGE   = 8'h74;
    localparam logic [7:0] OP_READ_SIGN   = 8'h75;
    localparam logic [7:0] END_OF_PACKET  = 8'h20;
    localparam logic [7:0] REPLY_SYNC     = 8'h14;
    localparam logic [7:0] REPLY_OK       = 8'h10;
    localparam logic [7:0] PARAM_MINOR    = 8'h82;
    localparam logic [7:0] PARAM_MAJOR    = 8'h81;
    localparam logic [7:0] PARAM_DEFAULT  = 8'h03;
    localparam logic [7:0] UNIV_REPLY     = 8'h00;
    localparam logic [8:0] SKIP_SET_DEV   = 9'd20;
    localparam logic [8:0] SKIP_SHORT     = 9'd4;

    localparam logic [2:0] REG_MINOR = 3'd0;
    localparam logic [2:0] REG_MAJOR = 3'd1;
    localparam logic [2:0] REG_SIG1  = 3'd2;
    localparam logic [2:0] REG_SIG2  = 3'd3;
    localparam logic [2:0] REG_SIG3  = 3'd4;
    localparam logic [2:0] REG_NORWW = 3'd5;

    typedef enum logic [3:0] {
        K_TX = 4'd0, K_ERASE = 4'd1, K_FILL = 4'd2, K_WRITE = 4'd3, K_RWW = 4'd4,
        K_READ = 4'd5, K_EEPROM = 4'd6, K_RESET = 4'd7, K_END = 4'd8
    } kind_t;

    // Back-end job classes
    typedef enum logic [3:0] {
        J_NONE, J_RESET, J_ERASE, J_EOP_ERR, J_REPLY, J_FILL, J_WRITE, J_RWW, J_READ_REQ,
        J_READ_DATA
    } job_t;

    // One classified request handed from front to back.
    typedef struct packed {
        job_t              job;
        logic [7:0]        op;       // command code for replies
        logic [7:0]        sel;      // parameter selector / data byte
        logic [ADDR_W-1:0] addr;
        logic              pgm_fill; // reply of program page starts fill
        logic              rd_done;  // read data that ends the page read
        logic [7:0]        fidx;     // fill index
        logic [8:0]        tlen;
    } job_req_t;

    typedef struct packed {
        logic [3:0]        kind;
        logic [7:0]        tx;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       word;
        logic              last;
    } res_t;

    function automatic res_t mk(input kind_t k, input logic [7:0] tx,
                                input logic [ADDR_W-1:0] a, input logic [15:0] w);
        res_t r;
        r.kind = k; r.tx = tx; r.addr = a; r.word = w; r.last = 1'b0;
        return r;
    endfunction
endpackage
`default_nettype wire

@@ design/stk_front.sv @@
// Front end: parses incoming requests and queues classified jobs.
`default_nettype none
module stk_front import stk_pkg::*; #(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_cmd,
    input  wire logic [7:0]        in_rx,
    input  wire logic [7:0]        in_fd,
    input  wire logic [ADDR_W-1:0] no_rww_start,
    input  wire logic              write_taken,
    output logic                   buf_we,
    output logic [7:0]             buf_waddr,
    output logic [7:0]             buf_wdata,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output job_req_t               job
);
    localparam int FILLS = PAGE_BYTES / 2;

    typedef enum logic [3:0] {
        PH_CMD, PH_SKIP, PH_PARAM, PH_ADDR_LO, PH_ADDR_HI, PH_LEN_HI, PH_LEN_LO,
        PH_MEMTYPE, PH_DATA, PH_EOP, PH_ERASE_WAIT, PH_FILL, PH_WRITE, PH_READ
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        code_reg, code_next;
    logic [8:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [8:0]        tlen_reg, tlen_next;
    logic              busy_reg, busy_next;
    logic [7:0]        fidx_reg, fidx_next;
    logic [7:0]        sel_reg, sel_next;
    logic              halt_reg, halt_next;
    logic              wpend_reg, wpend_next;
    logic [8:0]        cnt_inc;
    logic [ADDR_W-1:0] addr_inc;

    // page data waits until the back end has finished the previous page's fills
    assign in_ready = job_ready && !(wpend_reg && phase_reg == PH_DATA);
    wire acc = in_valid && in_ready;
    assign cnt_inc  = cnt_reg + 9'd1;
    assign addr_inc = addr_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg; code_next = code_reg; cnt_next = cnt_reg;
        addr_next = addr_reg; tlen_next = tlen_reg; busy_next = busy_reg;
        fidx_next = fidx_reg; sel_next = sel_reg; halt_next = halt_reg;
        wpend_next = wpend_reg;
        if (write_taken) wpend_next = 1'b0;
        buf_we = 1'b0; buf_waddr = cnt_reg[7:0]; buf_wdata = in_rx;
        job = '0; job.job = J_NONE; job.addr = addr_reg; job.tlen = tlen_reg;
        job.op = code_reg; job.sel = sel_reg; job.fidx = fidx_reg;
        if (acc && !halt_reg) begin
            case (in_cmd)
                CMD_SERIAL: begin
                    case (phase_reg)
                        PH_CMD: begin
                            code_next = in_rx;
                            case (in_rx)
                                OP_GET_PARAM: phase_next = PH_PARAM;
                                OP_SET_DEV: begin cnt_next = SKIP_SET_DEV; phase_next = PH_SKIP; end
                                OP_SET_DEV_EXT, OP_UNIVERSAL: begin
                                    cnt_next = SKIP_SHORT; phase_next = PH_SKIP;
                                end
                                OP_LOAD_ADDR: phase_next = PH_ADDR_LO;
                                OP_PROG_PAGE, OP_READ_PAGE: phase_next = PH_LEN_HI;
                                default: phase_next = PH_EOP;
                            endcase
                        end
                        PH_SKIP: begin
                            cnt_next = cnt_reg - 9'd1;
                            if (cnt_next == 9'd0) phase_next = PH_EOP;
                        end
                        PH_PARAM: begin sel_next = in_rx; phase_next = PH_EOP; end
                        PH_ADDR_LO: begin sel_next = in_rx; phase_next = PH_ADDR_HI; end
                        PH_ADDR_HI: begin
                            addr_next = {in_rx, sel_reg, 1'b0};
                            phase_next = PH_EOP;
                        end
                        PH_LEN_HI: phase_next = PH_LEN_LO;
                        PH_LEN_LO: begin
                            tlen_next = (in_rx == 8'd0) ? 9'd256 : {1'b0, in_rx};
                            phase_next = PH_MEMTYPE;
                        end
                        PH_MEMTYPE: begin
                            if (code_reg == OP_PROG_PAGE) begin
                                if (addr_reg < no_rww_start) begin
                                    job.job = J_ERASE; busy_next = 1'b1;
                                end
                                cnt_next = 9'd0; phase_next = PH_DATA;
                            end else phase_next = PH_EOP;
                        end
                        PH_DATA: begin
                            buf_we = !cnt_reg[8];
                            cnt_next = cnt_inc;
                            if (cnt_inc >= tlen_reg) begin
                                if (addr_reg >= no_rww_start) begin
                                    job.job = J_ERASE; busy_next = 1'b1;
                                end
                                phase_next = PH_EOP;
                            end
                        end
                        PH_EOP: begin
                            if (in_rx != END_OF_PACKET) begin
                                job.job = J_RESET; halt_next = 1'b1;
                            end else begin
                                job.job = J_REPLY;
                                phase_next = PH_CMD;
                                case (code_reg)
                                    OP_PROG_PAGE: begin
                                        if (busy_reg) phase_next = PH_ERASE_WAIT;
                                        else begin
                                            job.pgm_fill = 1'b1; job.fidx = 8'd0;
                                            fidx_next = 8'd0; phase_next = PH_FILL;
                                        end
                                    end
                                    OP_READ_PAGE: begin
                                        cnt_next = 9'd0; phase_next = PH_READ;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_FLASH_DATA: begin
                    if (phase_reg == PH_READ) begin
                        job.job = J_READ_DATA; job.sel = in_fd;
                        addr_next = addr_inc; job.addr = addr_inc;
                        cnt_next = cnt_inc;
                        job.rd_done = (cnt_inc >= tlen_reg);
                        if (job.rd_done) phase_next = PH_CMD;
                    end
                end
                CMD_FLASH_DONE: begin
                    busy_next = 1'b0;
                    case (phase_reg)
                        PH_ERASE_WAIT: begin
                            job.job = J_FILL; job.fidx = 8'd0;
                            fidx_next = 8'd0; phase_next = PH_FILL;
                        end
                        PH_FILL: begin
                            fidx_next = fidx_reg + 8'd1;
                            job.fidx = fidx_next;
                            if (32'(fidx_next) >= FILLS || fidx_next == 8'd0) begin
                                job.job = J_WRITE; busy_next = 1'b1;
                                wpend_next = 1'b1;
                                phase_next = PH_WRITE;
                            end else job.job = J_FILL;
                        end
                        PH_WRITE: begin job.job = J_RWW; phase_next = PH_CMD; end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        job_valid = (job.job != J_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CMD; code_reg <= '0; cnt_reg <= '0; addr_reg <= '0;
            tlen_reg <= '0; busy_reg <= 1'b0; fidx_reg <= '0; sel_reg <= '0;
            halt_reg <= 1'b0; wpend_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; code_reg <= code_next; cnt_reg <= cnt_next;
            addr_reg <= addr_next; tlen_reg <= tlen_next; busy_reg <= busy_next;
            fidx_reg <= fidx_next; sel_reg <= sel_next; halt_reg <= halt_next;
            wpend_reg <= wpend_next;
        end
    end
endmodule
`default_nettype wire

@@ design/stk_queue.sv @@
// Short job queue between front and back.
`default_nettype none
module stk_queue import stk_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  job_req_t  wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_req_t  rd_data
);
    localparam int AW = $clog2(DEPTH);
    job_req_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    wire wr = wr_valid && wr_ready;
    wire rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (32'(wp_reg) == DEPTH-1) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (32'(rp_reg) == DEPTH-1) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule
`default_nettype wire

@@ design/stk_back.sv @@
// Back end: expands queued jobs into result items, reading the page buffer.
`default_nettype none
module stk_back import stk_pkg::*; #(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  job_req_t               job,
    input  wire logic              buf_we,
    input  wire logic [7:0]        buf_waddr,
    input  wire logic [7:0]        buf_wdata,
    input  wire logic [7:0]        minor_version,
    input  wire logic [7:0]        major_version,
    input  wire logic [7:0]        sig1,
    input  wire logic [7:0]        sig2,
    input  wire logic [7:0]        sig3,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output res_t                   out_res
);
    // Buffer read is registered: every job waits for a load step (loaded_reg) before its first result.
    logic [7:0] buf_mem [BUFFER_BYTES];
    logic [7:0] rd_lo_reg, rd_hi_reg;
    logic       loaded_reg;
    job_req_t   cur_reg;
    logic       have_reg;
    logic [2:0] step_reg;
    res_t       seq [MAX_RES];
    logic [2:0] n_res;
    logic [8:0] i0, i1;
    logic [7:0] b0, b1;

    assign i0 = {job_ind(cur_reg.fidx), 1'b0};
    assign i1 = i0 + 9'd1;

    function automatic logic [7:0] job_ind(input logic [7:0] f);
        return f;
    endfunction

    always_ff @(posedge aclk) begin
        if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
        rd_lo_reg <= buf_mem[i0[7:0]];
        rd_hi_reg <= buf_mem[i1[7:0]];
    end

    always_comb begin
        b0 = (i0 < cur_reg.tlen && !i0[8]) ? rd_lo_reg : 8'hFF;
        b1 = (i1 < cur_reg.tlen && !i1[8]) ? rd_hi_reg : 8'hFF;
        for (int k = 0; k < MAX_RES; k++) seq[k] = mk(K_TX, 8'd0, '0, 16'd0);
        n_res = 3'd1;
        case (cur_reg.job)
            J_RESET: seq[0] = mk(K_RESET, 8'd0, '0, 16'd0);
            J_ERASE: seq[0] = mk(K_ERASE, 8'd0, cur_reg.addr, 16'd0);
            J_FILL:  seq[0] = mk(K_FILL, 8'd0, cur_reg.addr + ADDR_W'(i0), {b1, b0});
            J_WRITE: seq[0] = mk(K_WRITE, 8'd0, cur_reg.addr, 16'd0);
            J_RWW: begin
                seq[0] = mk(K_RWW, 8'd0, '0, 16'd0);
                seq[1] = mk(K_TX, REPLY_OK, '0, 16'd0); n_res = 3'd2;
            end
            J_READ_DATA: begin
                seq[0] = mk(K_TX, cur_reg.sel, '0, 16'd0); n_res = 3'd2;
                if (cur_reg.rd_done) seq[1] = mk(K_TX, REPLY_OK, '0, 16'd0);
                else seq[1] = mk(K_READ, 8'd0, cur_reg.addr, 16'd0);
            end
            J_REPLY: begin
                seq[0] = mk(K_TX, REPLY_SYNC, '0, 16'd0);
                case (cur_reg.op)
                    OP_GET_PARAM: begin
                        seq[1] = mk(K_TX, (cur_reg.sel == PARAM_MINOR) ? minor_version :
                                 (cur_reg.sel == PARAM_MAJOR) ? major_version :
                                 PARAM_DEFAULT, '0, 16'd0);
                        seq[2] = mk(K_TX, REPLY_OK, '0, 16'd0); n_res = 3'd3;
                    end
                    OP_UNIVERSAL: begin
                        seq[1] = mk(K_TX, UNIV_REPLY, '0, 16'd0);
                        seq[2] = mk(K_TX, REPLY_OK, '0, 16'd0); n_res = 3'd3;
                    end
                    OP_PROG_PAGE: begin
                        if (cur_reg.pgm_fill) begin
                            seq[1] = mk(K_FILL, 8'd0, cur_reg.addr + ADDR_W'(i0), {b1, b0});
                            n_res = 3'd2;
                        end
                    end
                    OP_READ_PAGE: begin
                        seq[1] = mk(K_READ, 8'd0, cur_reg.addr, 16'd0); n_res = 3'd2;
                    end
                    OP_READ_SIGN: begin
                        seq[1] = mk(K_TX, sig1, '0, 16'd0);
                        seq[2] = mk(K_TX, sig2, '0, 16'd0);
                        seq[3] = mk(K_TX, sig3, '0, 16'd0);
                        seq[4] = mk(K_TX, REPLY_OK, '0, 16'd0); n_res = 3'd5;
                    end
                    OP_LEAVE: begin
                        seq[1] = mk(K_EEPROM, 8'd0, '0, 16'd0);
                        seq[2] = mk(K_TX, REPLY_OK, '0, 16'd0);
                        seq[3] = mk(K_END, 8'd0, '0, 16'd0); n_res = 3'd4;
                    end
                    default: begin
                        seq[1] = mk(K_TX, REPLY_OK, '0, 16'd0); n_res = 3'd2;
                    end
                endcase
            end
            default: ;
        endcase
        out_res = seq[step_reg];
        out_res.last = (step_reg == n_res - 3'd1);
    end

    assign out_valid = have_reg && loaded_reg;
    wire done = out_valid && out_ready && out_res.last;
    assign job_ready = !have_reg || done;

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) cur_reg <= job;
        if (!aresetn) begin
            have_reg <= 1'b0; step_reg <= '0; loaded_reg <= 1'b0;
        end else begin
            if (job_valid && job_ready) begin
                have_reg <= 1'b1; step_reg <= '0; loaded_reg <= 1'b0;
            end else begin
                if (done) have_reg <= 1'b0;
                if (have_reg) loaded_reg <= 1'b1;
                if (out_valid && out_ready && !out_res.last) step_reg <= step_reg + 3'd1;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/stk500_bootloader_command_engine_core.sv @@
// Top level of the STK500 command engine: config registers, front, queue, back.
//
//  channel | direction | payload
//  s_      | in        | tdata: cmd[1:0], rx_byte[9:2], flash_data[17:10]
//  m_      | out       | tdata: kind[3:0], tx_byte[11:4], flash_address[28:12],
//          |           |        fill_word[44:29]; tlast: last
//  cfg_    | in        | index[2:0], data[16:0]
//
// The front parses one request per cycle while s_tready is high; each job then leaves
// the back end as one result per cycle while m_tready is high, after a registered page
// buffer read (loaded_reg) that every job waits for. The queue holds four jobs.
// Reset (aresetn low, synchronous) clears parser state and config to defaults.
// A stalled m_ side fills the queue, then drops s_tready. Page data of a new
// program page also waits until the previous page write has reached the back end.
`default_nettype none
module stk500_bootloader_command_engine_core import stk_pkg::*; #(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // cmd, rx_byte, flash_data
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // kind, tx_byte, flash_address, fill_word
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    logic [7:0]        minor_reg, major_reg, sig1_reg, sig2_reg, sig3_reg;
    logic [ADDR_W-1:0] norww_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minor_reg <= 8'd0; major_reg <= 8'd0; sig1_reg <= 8'd30;
            sig2_reg <= 8'd149; sig3_reg <= 8'd15; norww_reg <= 17'd28672;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MINOR: minor_reg <= cfg_data[7:0];
                REG_MAJOR: major_reg <= cfg_data[7:0];
                REG_SIG1:  sig1_reg  <= cfg_data[7:0];
                REG_SIG2:  sig2_reg  <= cfg_data[7:0];
                REG_SIG3:  sig3_reg  <= cfg_data[7:0];
                REG_NORWW: norww_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic       buf_we;
    logic [7:0] buf_waddr, buf_wdata;
    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    logic       wr_taken;
    job_req_t   fq_job, qb_job;
    res_t       res;

    // back end picks up a page write: all fills of that page are done
    assign wr_taken = qb_valid && qb_ready && (qb_job.job == J_WRITE);

    stk_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_rx(s_tdata[9:2]), .in_fd(s_tdata[17:10]),
        .no_rww_start(norww_reg), .write_taken(wr_taken),
        .buf_we, .buf_waddr, .buf_wdata,
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    stk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
    );

    stk_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
        .aclk, .aresetn, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .buf_we, .buf_waddr, .buf_wdata, .minor_version(minor_reg),
        .major_version(major_reg), .sig1(sig1_reg), .sig2(sig2_reg), .sig3(sig3_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {3'd0, res.word, res.addr, res.tx, res.kind};
    assign m_tlast = res.last;
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for the STK500 command engine: directed table, then random sessions.
module tb;
    import stk_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES = 250;

    // parser phases of the bench's own model
    typedef enum {
        P_CMD, P_SKIP, P_PARAM, P_ADDR_LO, P_ADDR_HI, P_LEN_HI, P_LEN_LO, P_MEMTYPE,
        P_DATA, P_EOP, P_ERASE_WAIT, P_FILL, P_WRITE, P_READ
    } parse_t;

    // one row of the directed table; typed holds up to five {kind, tx} pairs,
    // first result in the top bits, used only when n_typed is non-zero
    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  val;
        int          n_typed;
        logic [59:0] typed;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // cmd[1:0], rx_byte[9:2], flash_data[17:10]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // kind[3:0], tx_byte[11:4], flash_address[28:12], fill_word[44:29]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    stk500_bootloader_command_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // engine model state
    logic [7:0]  reg_minor, reg_major, reg_sig1, reg_sig2, reg_sig3;
    logic [16:0] reg_norww;
    parse_t      ph;
    logic [7:0]  op_code;
    logic [8:0]  byte_cnt;
    logic [16:0] cur_addr;
    logic [8:0]  xfer_len;
    logic [7:0]  page_buf [256];
    logic        busy;
    logic [7:0]  fill_idx;
    logic [7:0]  sel_byte;
    logic        stopped;

    res_t step_results[$];
    res_t expected_results[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  burst_left = 0;
    bit  burst_ready = 1'b1;
    int  items_sent = 0;

    function automatic res_t make_res(logic [3:0] k, logic [7:0] tx, logic [16:0] a,
                                      logic [15:0] w);
        res_t r;
        r.kind = k; r.tx = tx; r.addr = a; r.word = w; r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] page_byte(int idx);
        if (idx < xfer_len && idx < 256) return page_buf[idx];
        return 8'hFF;
    endfunction

    task automatic push_fill();
        int i;
        logic [15:0] w;
        i = fill_idx * 2;
        w = {page_byte(i + 1), page_byte(i)};
        step_results.push_back(make_res(K_FILL, 8'h00, cur_addr + 17'(i), w));
    endtask

    task automatic push_tx(logic [7:0] b);
        step_results.push_back(make_res(K_TX, b, '0, '0));
    endtask

    task automatic end_packet(logic [7:0] b);
        if (b != END_OF_PACKET) begin
            step_results.push_back(make_res(K_RESET, 8'h00, '0, '0));
            stopped = 1'b1;
            return;
        end
        push_tx(REPLY_SYNC);
        ph = P_CMD;
        case (op_code)
            OP_GET_PARAM: begin
                if (sel_byte == PARAM_MINOR) push_tx(reg_minor);
                else if (sel_byte == PARAM_MAJOR) push_tx(reg_major);
                else push_tx(PARAM_DEFAULT);
                push_tx(REPLY_OK);
            end
            OP_UNIVERSAL: begin
                push_tx(UNIV_REPLY);
                push_tx(REPLY_OK);
            end
            OP_PROG_PAGE: begin
                if (busy) ph = P_ERASE_WAIT;
                else begin
                    fill_idx = 0;
                    push_fill();
                    ph = P_FILL;
                end
            end
            OP_READ_PAGE: begin
                byte_cnt = 0;
                step_results.push_back(make_res(K_READ, 8'h00, cur_addr, '0));
                ph = P_READ;
            end
            OP_READ_SIGN: begin
                push_tx(reg_sig1);
                push_tx(reg_sig2);
                push_tx(reg_sig3);
                push_tx(REPLY_OK);
            end
            OP_LEAVE: begin
                step_results.push_back(make_res(K_EEPROM, 8'h00, '0, '0));
                push_tx(REPLY_OK);
                step_results.push_back(make_res(K_END, 8'h00, '0, '0));
            end
            default: push_tx(REPLY_OK);
        endcase
    endtask

    // Works out the results of one request and advances the model state.
    task automatic step_engine(logic [1:0] c, logic [7:0] b, logic [7:0] fd);
        step_results.delete();
        if (stopped) return;
        if (c == CMD_SERIAL) begin
            case (ph)
                P_CMD: begin
                    op_code = b;
                    if (b == OP_GET_PARAM) ph = P_PARAM;
                    else if (b == OP_SET_DEV) begin byte_cnt = SKIP_SET_DEV; ph = P_SKIP; end
                    else if (b == OP_SET_DEV_EXT || b == OP_UNIVERSAL) begin
                        byte_cnt = SKIP_SHORT; ph = P_SKIP;
                    end
                    else if (b == OP_LOAD_ADDR) ph = P_ADDR_LO;
                    else if (b == OP_PROG_PAGE || b == OP_READ_PAGE) ph = P_LEN_HI;
                    else ph = P_EOP;
                end
                P_SKIP: begin
                    byte_cnt = byte_cnt - 9'd1;
                    if (byte_cnt == 0) ph = P_EOP;
                end
                P_PARAM: begin sel_byte = b; ph = P_EOP; end
                P_ADDR_LO: begin sel_byte = b; ph = P_ADDR_HI; end
                P_ADDR_HI: begin cur_addr = {b, sel_byte, 1'b0}; ph = P_EOP; end
                P_LEN_HI: ph = P_LEN_LO;
                P_LEN_LO: begin
                    xfer_len = (b == 0) ? 9'd256 : {1'b0, b};
                    ph = P_MEMTYPE;
                end
                P_MEMTYPE: begin
                    if (op_code == OP_PROG_PAGE) begin
                        if (cur_addr < reg_norww) begin
                            step_results.push_back(make_res(K_ERASE, 8'h00, cur_addr, '0));
                            busy = 1'b1;
                        end
                        byte_cnt = 0;
                        ph = P_DATA;
                    end else ph = P_EOP;
                end
                P_DATA: begin
                    if (byte_cnt < 256) page_buf[byte_cnt[7:0]] = b;
                    byte_cnt = byte_cnt + 9'd1;
                    if (byte_cnt >= xfer_len) begin
                        if (cur_addr >= reg_norww) begin
                            step_results.push_back(make_res(K_ERASE, 8'h00, cur_addr, '0));
                            busy = 1'b1;
                        end
                        ph = P_EOP;
                    end
                end
                P_EOP: end_packet(b);
                default: ;
            endcase
        end else if (c == CMD_FLASH_DATA) begin
            if (ph == P_READ) begin
                push_tx(fd);
                cur_addr = cur_addr + 17'd1;
                byte_cnt = byte_cnt + 9'd1;
                if (byte_cnt >= xfer_len) begin
                    push_tx(REPLY_OK);
                    ph = P_CMD;
                end else step_results.push_back(make_res(K_READ, 8'h00, cur_addr, '0));
            end
        end else if (c == CMD_FLASH_DONE) begin
            busy = 1'b0;
            if (ph == P_ERASE_WAIT) begin
                fill_idx = 0;
                push_fill();
                ph = P_FILL;
            end else if (ph == P_FILL) begin
                fill_idx = fill_idx + 8'd1;
                if (fill_idx >= PAGE_BYTES_DEF / 2) begin
                    step_results.push_back(make_res(K_WRITE, 8'h00, cur_addr, '0));
                    busy = 1'b1;
                    ph = P_WRITE;
                end else push_fill();
            end else if (ph == P_WRITE) begin
                step_results.push_back(make_res(K_RWW, 8'h00, '0, '0));
                push_tx(REPLY_OK);
                ph = P_CMD;
            end
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // Offers one request on the s_ side; returns once it has been taken.
    task automatic drive_request(logic [1:0] c, logic [7:0] b, logic [7:0] fd);
        int gap;
        @(negedge aclk);
        gap = 0;
        if (gaps_on) begin
            if ($urandom_range(0, 99) < 25) gap = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 4) gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, fd, b, c};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic issue(logic [1:0] c, logic [7:0] b, logic [7:0] fd);
        step_engine(c, b, fd);
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
        drive_request(c, b, fd);
    endtask

    task automatic issue_serial(logic [7:0] b);
        issue(CMD_SERIAL, b, 8'($urandom));
    endtask

    // Requests the engine ignores in the current phase.
    task automatic issue_noise();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) issue(CMD_RESERVED, 8'($urandom), 8'($urandom));
        else if (r == 1 && ph != P_READ) issue(CMD_FLASH_DATA, 8'($urandom), 8'($urandom));
        else if (ph inside {P_FILL, P_WRITE, P_ERASE_WAIT, P_READ})
            issue_serial(8'($urandom));
        else issue(CMD_RESERVED, 8'($urandom), 8'($urandom));
    endtask

    // Completes whatever command is open, acting as host and flash side.
    task automatic finish_command();
        while (ph != P_CMD && !stopped) begin
            if ($urandom_range(0, 99) < 8) issue_noise();
            case (ph)
                P_EOP: issue_serial(END_OF_PACKET);
                P_ERASE_WAIT, P_FILL, P_WRITE: issue(CMD_FLASH_DONE, 8'($urandom), 8'($urandom));
                P_READ: issue(CMD_FLASH_DATA, 8'($urandom), 8'($urandom));
                default: issue_serial(8'($urandom));
            endcase
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MINOR: reg_minor = val[7:0];
            REG_MAJOR: reg_major = val[7:0];
            REG_SIG1:  reg_sig1  = val[7:0];
            REG_SIG2:  reg_sig2  = val[7:0];
            REG_SIG3:  reg_sig3  = val[7:0];
            REG_NORWW: reg_norww = val;
            default: ;
        endcase
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_regs(int set_id);
        logic [16:0] v [6];
        foreach (v[i]) v[i] = 17'($urandom);
        if (set_id == 1) foreach (v[i]) v[i] = '0;
        if (set_id == 2) foreach (v[i]) v[i] = 17'h1FFFF;
        write_reg(REG_MINOR, v[0]);
        write_reg(REG_MAJOR, v[1]);
        write_reg(REG_SIG1, v[2]);
        write_reg(REG_SIG2, v[3]);
        write_reg(REG_SIG3, v[4]);
        write_reg(REG_NORWW, v[5]);
    endtask

    task automatic random_command();
        int r;
        logic [7:0] len;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            issue_serial(OP_GET_PARAM);
            r = $urandom_range(0, 2);
            issue_serial(r == 0 ? PARAM_MINOR : r == 1 ? PARAM_MAJOR : 8'($urandom));
        end
        else if (r < 17) issue_serial(OP_SET_DEV);
        else if (r < 22) issue_serial(OP_SET_DEV_EXT);
        else if (r < 28) issue_serial(OP_UNIVERSAL);
        else if (r < 42) issue_serial(OP_LOAD_ADDR);
        else if (r < 48) begin
            // mostly short pages, so the tail fills as 0xFF
            len = 8'($urandom_range(1, 24));
            if ($urandom_range(0, 7) == 0) len = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            issue_serial(OP_PROG_PAGE);
            issue_serial(8'($urandom));
            issue_serial(len);
        end
        else if (r < 60) begin
            len = 8'($urandom_range(1, 8));
            if ($urandom_range(0, 19) == 0) len = 8'h00;
            issue_serial(OP_READ_PAGE);
            issue_serial(8'($urandom));
            issue_serial(len);
        end
        else if (r < 67) issue_serial(OP_READ_SIGN);
        else if (r < 73) issue_serial(OP_LEAVE);
        else if (r < 82) issue_serial(8'($urandom));     // unknown or broken sequence
        else issue_noise();
        finish_command();
    endtask

    dir_row_t directed_rows [] = '{
        '{CMD_RESERVED,   8'hA5, 0, '0},
        '{CMD_FLASH_DATA, 8'h00, 0, '0},
        '{CMD_FLASH_DONE, 8'hFF, 0, '0},
        '{CMD_SERIAL, OP_GET_PARAM, 0, '0},
        '{CMD_SERIAL, PARAM_MAJOR, 0, '0},
        '{CMD_SERIAL, END_OF_PACKET, 3,
          {K_TX, REPLY_SYNC, K_TX, 8'h00, K_TX, REPLY_OK, 24'h0}},
        '{CMD_SERIAL, OP_GET_PARAM, 0, '0},
        '{CMD_SERIAL, 8'hFF, 0, '0},
        '{CMD_SERIAL, END_OF_PACKET, 3,
          {K_TX, REPLY_SYNC, K_TX, PARAM_DEFAULT, K_TX, REPLY_OK, 24'h0}},
        '{CMD_SERIAL, OP_READ_SIGN, 0, '0},
        '{CMD_SERIAL, END_OF_PACKET, 5,
          {K_TX, REPLY_SYNC, K_TX, 8'h1E, K_TX, 8'h95, K_TX, 8'h0F, K_TX, REPLY_OK}},
        '{CMD_SERIAL, OP_LEAVE, 0, '0},
        '{CMD_SERIAL, END_OF_PACKET, 4,
          {K_TX, REPLY_SYNC, K_EEPROM, 8'h00, K_TX, REPLY_OK, K_END, 8'h00, 12'h0}},
        '{CMD_SERIAL, OP_LOAD_ADDR, 0, '0},
        '{CMD_SERIAL, 8'hFF, 0, '0},
        '{CMD_SERIAL, 8'hFF, 0, '0},
        '{CMD_SERIAL, END_OF_PACKET, 2, {K_TX, REPLY_SYNC, K_TX, REPLY_OK, 36'h0}},
        // page read across the top of the address space, wraps to zero
        '{CMD_SERIAL, OP_READ_PAGE, 0, '0},
        '{CMD_SERIAL, 8'hFF, 0, '0},
        '{CMD_SERIAL, 8'h02, 0, '0},
        '{CMD_SERIAL, 8'hFF, 0, '0},
        '{CMD_SERIAL, END_OF_PACKET, 0, '0},
        '{CMD_FLASH_DATA, 8'hFF, 0, '0},
        '{CMD_FLASH_DATA, 8'h00, 0, '0},
        '{CMD_SERIAL, 8'h00, 0, '0}
    };

    // result side: random ready, occasional long stall on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(20, 120);
                burst_ready = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            if (burst_ready) m_tready <= 1'b1;
            else if ($urandom_range(0, 49) == 0) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(0, 99) < 65);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tdata[3:0];
            got.tx   = m_tdata[11:4];
            got.addr = m_tdata[28:12];
            got.word = m_tdata[44:29];
            got.last = m_tlast;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d tx=%h addr=%h word=%h last=%b",
                             got.kind, got.tx, got.addr, got.word, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp kind=%0d tx=%h addr=%h word=%h last=%b, got kind=%0d tx=%h addr=%h word=%h last=%b",
                                 want.kind, want.tx, want.addr, want.word, want.last,
                                 got.kind, got.tx, got.addr, got.word, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int phase_no;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reg_minor = 8'd0; reg_major = 8'd0;
        reg_sig1 = 8'd30; reg_sig2 = 8'd149; reg_sig3 = 8'd15;
        reg_norww = 17'd28672;
        ph = P_CMD; op_code = '0; byte_cnt = '0; cur_addr = '0; xfer_len = '0;
        busy = 1'b0; fill_idx = '0; sel_byte = '0; stopped = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, at reset register values
        foreach (directed_rows[i]) begin
            step_engine(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].val);
            if (directed_rows[i].n_typed > 0) begin
                for (int k = 0; k < directed_rows[i].n_typed; k++)
                    expected_results.push_back(make_res(
                        directed_rows[i].typed[59 - 12 * k -: 4],
                        directed_rows[i].typed[55 - 12 * k -: 8], '0, '0));
                expected_results[expected_results.size() - 1].last = 1'b1;
            end else foreach (step_results[j]) expected_results.push_back(step_results[j]);
            drive_request(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].val);
        end
        finish_command();

        // random part in four register settings
        items_sent = 0;
        for (phase_no = 0; phase_no < 4; phase_no++) begin
            wait_quiet();
            load_regs(phase_no);
            gaps_on = (phase_no != 3);
            if (phase_no == 1) hold_request = 1'b1;
            while (items_sent < (phase_no + 1) * RANDOM_ITEMS / 4) random_command();
        end

        // bad end of packet, after which the engine stays halted
        issue_serial(OP_READ_SIGN);
        issue_serial(8'h21);
        issue_serial(OP_READ_SIGN);

        wait_quiet();
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ filelist.f @@
design/stk_pkg.sv
design/stk_front.sv
design/stk_queue.sv
design/stk_back.sv
design/stk500_bootloader_command_engine_core.sv
test/tb.sv
